// ===== design/mlde_pkg.sv =====
`timescale 1ns / 1ps

package mlde_pkg;

  typedef logic [3:0] digit_t;

  localparam digit_t BLANK_DIGIT = 4'd10;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned WORD_COUNT = 11;
  localparam logic [3:0] LAST_WORD = 4'(WORD_COUNT - 1);
  localparam logic [3:0] LAST_RAM_INDEX = 4'd13;
  localparam logic [3:0] POINT_RAM_INDEX = 4'd2;
  localparam int unsigned POINT_BIT = 27;

  // one display update, digits already blanked
  typedef struct packed {
    logic   icons;
    logic   bar_max;
    logic   bar_mid;
    logic   bar_min;
    digit_t tt;
    digit_t th;
    digit_t hu;
    digit_t te;
    digit_t un;
    digit_t p1;
    digit_t p2;
    digit_t p3;
  } disp_entry_t;

  // three-segment half of a digit
  function automatic logic [3:0] seg_a(input digit_t d);
    logic [3:0] s;
    case (d)
      4'd0: s = 4'h7;
      4'd1: s = 4'h6;
      4'd2: s = 4'h3;
      4'd3: s = 4'h7;
      4'd4: s = 4'h6;
      4'd5: s = 4'h5;
      4'd6: s = 4'h5;
      4'd7: s = 4'h7;
      4'd8: s = 4'h7;
      4'd9: s = 4'h7;
      default: s = 4'h0;
    endcase
    return s;
  endfunction

  // four-segment half of a digit
  function automatic logic [3:0] seg_b(input digit_t d);
    logic [3:0] s;
    case (d)
      4'd0: s = 4'hD;
      4'd1: s = 4'h0;
      4'd2: s = 4'hE;
      4'd3: s = 4'hA;
      4'd4: s = 4'h3;
      4'd5: s = 4'hB;
      4'd6: s = 4'hF;
      4'd7: s = 4'h0;
      4'd8: s = 4'hF;
      4'd9: s = 4'hB;
      default: s = 4'h0;
    endcase
    return s;
  endfunction

  // display RAM index for each position of the write sequence
  function automatic logic [3:0] ram_index_of(input logic [3:0] k);
    logic [3:0] i;
    case (k)
      4'd0:  i = 4'd5;
      4'd1:  i = 4'd4;
      4'd2:  i = 4'd3;
      4'd3:  i = 4'd10;
      4'd4:  i = 4'd11;
      4'd5:  i = 4'd8;
      4'd6:  i = 4'd9;
      4'd7:  i = 4'd1;
      4'd8:  i = 4'd2;
      4'd9:  i = 4'd12;
      4'd10: i = 4'd13;
      default: i = 4'd0;
    endcase
    return i;
  endfunction

endpackage

// ===== design/mlde_front.sv =====
`timescale 1ns / 1ps

module mlde_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [16:0]           in_integer_value,
  input  logic [13:0]           in_fraction_value,
  input  logic [7:0]            in_point_mode,
  input  logic [7:0]            in_battery_level,
  output logic                  q_push,
  output mlde_pkg::disp_entry_t q_entry,
  input  logic                  q_full
);
  import mlde_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_SPLIT = 3'b010,
    F_PUSH  = 3'b100
  } fstate_t;

  typedef struct packed {
    digit_t      dig;
    logic [16:0] rem;
  } split_t;

  localparam logic [2:0] STEP_LAST = 3'd4;
  localparam logic [2:0] FRAC_STEPS = 3'd4;

  // one decimal digit: x is known to be below ten times pw
  function automatic split_t split_digit(input logic [16:0] x, input logic [16:0] pw);
    split_t      r;
    logic [20:0] m;
    r.dig = '0;
    r.rem = x;
    for (int k = 1; k < 10; k++) begin
      m = 21'(pw) * 21'(k);
      if (21'(x) >= m) begin
        r.dig = 4'(k);
        r.rem = 17'(21'(x) - m);
      end
    end
    return r;
  endfunction

  fstate_t            st_r, st_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [16:0]        iv_r, iv_nxt;
  logic [13:0]        fv_r, fv_nxt;
  logic               icons_r, icons_nxt;
  logic [2:0]         bars_r, bars_nxt;
  logic [4:0][3:0]    idig_r, idig_nxt;
  logic [3:0][3:0]    fdig_r, fdig_nxt;

  logic               accept;
  logic               in_icons;
  logic [16:0]        iv_sat;
  logic [13:0]        fv_sat;
  logic [13:0]        fv_norm;
  logic [16:0]        pw_int;
  logic [16:0]        pw_frac;
  split_t             sp_int;
  split_t             sp_frac;
  disp_entry_t        ent;

  assign in_ready = (st_r == F_IDLE) || ((st_r == F_PUSH) && !q_full);
  assign accept   = in_valid && in_ready;
  assign q_push   = (st_r == F_PUSH) && !q_full;
  assign q_entry  = ent;

  assign in_icons = (in_point_mode == 8'd0);
  assign iv_sat   = (in_integer_value > 17'd99999) ? 17'd99999 : in_integer_value;
  assign fv_sat   = (in_fraction_value > 14'd9999) ? 14'd9999 : in_fraction_value;

  // left-justify a short fraction when the point mode asks for it
  always_comb begin
    fv_norm = fv_sat;
    if (!in_icons && (fv_sat < 14'd1000)) begin
      if (fv_sat >= 14'd100) begin
        fv_norm = 14'(fv_sat * 14'd10);
      end else if (fv_sat >= 14'd10) begin
        fv_norm = 14'(fv_sat * 14'd100);
      end else begin
        fv_norm = 14'(fv_sat * 14'd1000);
      end
    end
  end

  always_comb begin
    case (step_r)
      3'd0: pw_int = 17'd10000;
      3'd1: pw_int = 17'd1000;
      3'd2: pw_int = 17'd100;
      3'd3: pw_int = 17'd10;
      default: pw_int = 17'd1;
    endcase
    case (step_r)
      3'd0: pw_frac = 17'd1000;
      3'd1: pw_frac = 17'd100;
      3'd2: pw_frac = 17'd10;
      default: pw_frac = 17'd1;
    endcase
  end

  assign sp_int  = split_digit(iv_r, pw_int);
  assign sp_frac = split_digit({3'b000, fv_r}, pw_frac);

  always_comb begin
    st_nxt    = st_r;
    step_nxt  = step_r;
    iv_nxt    = iv_r;
    fv_nxt    = fv_r;
    icons_nxt = icons_r;
    bars_nxt  = bars_r;
    idig_nxt  = idig_r;
    fdig_nxt  = fdig_r;
    case (st_r)
      F_SPLIT: begin
        idig_nxt = {idig_r[3:0], sp_int.dig};
        iv_nxt   = sp_int.rem;
        if (step_r < FRAC_STEPS) begin
          fdig_nxt = {fdig_r[2:0], sp_frac.dig};
          fv_nxt   = sp_frac.rem[13:0];
        end
        if (step_r == STEP_LAST) begin
          st_nxt = F_PUSH;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      F_PUSH: begin
        if (q_push) begin
          st_nxt = F_IDLE;
        end
      end
      F_IDLE: begin
        st_nxt = F_IDLE;
      end
      default: begin
        st_nxt = F_IDLE;
      end
    endcase
    if (accept) begin
      st_nxt    = F_SPLIT;
      step_nxt  = '0;
      iv_nxt    = iv_sat;
      fv_nxt    = fv_norm;
      icons_nxt = in_icons;
      bars_nxt  = '0;
      if (in_icons) begin
        case (in_battery_level)
          8'd3: bars_nxt = 3'b111;
          8'd2: bars_nxt = 3'b011;
          8'd1: bars_nxt = 3'b001;
          default: bars_nxt = 3'b000;
        endcase
      end
    end
  end

  // leading zero blanking on the integer, trailing on the fraction unless icons are shown
  always_comb begin
    ent.icons   = icons_r;
    ent.bar_max = bars_r[2];
    ent.bar_mid = bars_r[1];
    ent.bar_min = bars_r[0];
    ent.tt = idig_r[4];
    ent.th = idig_r[3];
    ent.hu = idig_r[2];
    ent.te = idig_r[1];
    ent.un = idig_r[0];
    ent.p1 = fdig_r[3];
    ent.p2 = fdig_r[2];
    ent.p3 = fdig_r[1];
    if (idig_r[4] == 4'd0) begin
      ent.tt = BLANK_DIGIT;
      if (idig_r[3] == 4'd0) begin
        ent.th = BLANK_DIGIT;
        if (idig_r[2] == 4'd0) begin
          ent.hu = BLANK_DIGIT;
          if (idig_r[1] == 4'd0) begin
            ent.te = BLANK_DIGIT;
          end
        end
      end
    end
    if (!icons_r && (fdig_r[0] == 4'd0) && (fdig_r[1] == 4'd0)) begin
      ent.p3 = BLANK_DIGIT;
      if (fdig_r[2] == 4'd0) begin
        ent.p2 = BLANK_DIGIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iv_r    <= iv_nxt;
    fv_r    <= fv_nxt;
    icons_r <= icons_nxt;
    bars_r  <= bars_nxt;
    idig_r  <= idig_nxt;
    fdig_r  <= fdig_nxt;
  end

endmodule

// ===== design/mlde_queue.sv =====
`timescale 1ns / 1ps

module mlde_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mlde_pkg::disp_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output mlde_pkg::disp_entry_t head_entry
);
  import mlde_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  disp_entry_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     do_push;
  logic                     do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== design/mlde_back.sv =====
`timescale 1ns / 1ps

module mlde_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  mlde_pkg::disp_entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_ram_index,
  output logic [31:0]           out_ram_word,
  output logic                  out_last
);
  import mlde_pkg::*;

  function automatic logic [31:0] pa(input digit_t d, input int unsigned sh);
    return 32'(seg_a(d)) << sh;
  endfunction

  function automatic logic [31:0] pb(input digit_t d, input int unsigned sh);
    return 32'(seg_b(d)) << sh;
  endfunction

  function automatic logic [31:0] build_word(input disp_entry_t e, input logic [3:0] k);
    logic [31:0] w;
    case (k)
      4'd0: w = pa(e.tt, 0) | (32'(e.icons) << 8) | (32'(e.icons) << 10)
              | (32'(e.icons) << 26) | (32'(e.bar_mid) << 3);
      4'd1: w = pb(e.th, 16) | pa(e.th, 8) | pb(e.tt, 24) | (32'(e.bar_min) << 11);
      4'd2: w = pb(e.un, 0) | pb(e.te, 16) | pa(e.te, 8) | pa(e.hu, 24)
              | (32'(e.bar_max) << 27);
      4'd3: w = pa(e.p1, 16);
      4'd4: w = pb(e.p1, 16);
      4'd5: w = pa(e.p2, 16);
      4'd6: w = pb(e.p2, 16);
      4'd7: w = pa(e.p3, 24) | pb(e.hu, 8);
      4'd8: w = pb(e.p3, 0) | pa(e.un, 24) | (32'd1 << POINT_BIT);
      default: w = '0;
    endcase
    return w;
  endfunction

  logic        act_r, act_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  disp_entry_t cur_r, cur_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_index_r;
  logic [31:0] out_word_r;
  logic        out_last_r;

  logic        out_free;
  logic        emit;
  logic        finishing;

  assign out_free  = !out_valid_r || out_ready;
  assign emit      = act_r && out_free;
  assign finishing = emit && (cnt_r == LAST_WORD);
  // next update is picked up when idle, or in the cycle the last word is loaded into the output register
  assign q_pop     = q_valid && (!act_r || finishing);

  assign out_valid     = out_valid_r;
  assign out_ram_index = out_index_r;
  assign out_ram_word  = out_word_r;
  assign out_last      = out_last_r;

  always_comb begin
    act_nxt       = act_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      cnt_nxt       = cnt_r + 4'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finishing) begin
      act_nxt = 1'b0;
    end
    if (q_pop) begin
      act_nxt = 1'b1;
      cnt_nxt = '0;
      cur_nxt = q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      out_index_r <= ram_index_of(cnt_r);
      out_word_r  <= build_word(cur_r, cnt_r);
      out_last_r  <= (cnt_r == LAST_WORD);
    end
  end

`ifndef SYNTHESIS
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_index_r == LAST_RAM_INDEX)
    else $error("last word not at final ram index");

  a_last_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_index_r != LAST_RAM_INDEX)
    else $error("final ram index without last flag");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> cnt_r <= LAST_WORD)
    else $error("word counter past end of sequence");

  a_point_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_index_r == POINT_RAM_INDEX |-> out_word_r[POINT_BIT])
    else $error("decimal point missing");
`endif

endmodule

// ===== design/meter_lcd_digit_encoder.sv =====
`timescale 1ns / 1ps

// LCD digit encoder for a meter display.
// in_ channel: one word per display update (integer part, fraction part,
//   point mode, battery level), valid/ready handshake.
// out_ channel: eleven display RAM writes per update, in index order
//   5,4,3,10,11,8,9,1,2,12,13, with out_last set on the eleventh.
// after an input is accepted the first write passes through 5 digit steps,
//   the queue hand-off, the back-end load and the output register.
// throughput: the output register offers one word per cycle while out_ready
//   is high; updates back up without gaps between runs.
// the front end splits digits one per cycle and takes a new word only when
//   idle or pushing the last; a two-entry queue lets it run ahead of the output side.
// reset (rst_n low, synchronous) empties the queue and drops any run in
//   progress; no words are offered until a new input arrives.
// when the receiver drops out_ready the current write holds on the port,
//   the queue fills and then in_ready falls until space frees up.

module meter_lcd_digit_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] in_integer_value,
  input  logic [13:0] in_fraction_value,
  input  logic [7:0]  in_point_mode,
  input  logic [7:0]  in_battery_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_ram_index,
  output logic [31:0] out_ram_word,
  output logic        out_last
);
  import mlde_pkg::*;

  logic        push;
  logic        full;
  logic        pop;
  logic        head_valid;
  disp_entry_t push_entry;
  disp_entry_t head_entry;

  mlde_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_integer_value  (in_integer_value),
    .in_fraction_value (in_fraction_value),
    .in_point_mode     (in_point_mode),
    .in_battery_level  (in_battery_level),
    .q_push            (push),
    .q_entry           (push_entry),
    .q_full            (full)
  );

  mlde_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  mlde_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (head_valid),
    .q_entry       (head_entry),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ram_index (out_ram_index),
    .out_ram_word  (out_ram_word),
    .out_last      (out_last)
  );

endmodule
